/* design/pva_pkg.sv */
package pva_pkg;

   // Voice table size and derived widths
   localparam int VOICES   = 16;
   localparam int IDXW     = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int MAX_RES  = 16;
   localparam int CNTW     = $clog2(MAX_RES + 1);
   localparam int AGEW     = 32;
   localparam int EXPRW    = 24;

   localparam logic [IDXW-1:0]  LAST_IDX     = IDXW'(VOICES - 1);
   localparam logic [EXPRW-1:0] DEFAULT_EXPR = 24'h00FF00;

   // Input commands
   typedef enum logic [1:0] {
      CMD_NOTE_ON  = 2'd0,
      CMD_NOTE_OFF = 2'd1,
      CMD_EXPR     = 2'd2,
      CMD_RETIRE   = 2'd3
   } cmd_type;

   // Result actions
   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_STARTED   = 3'd1,
      ACT_STOLEN    = 3'd2,
      ACT_RELEASING = 3'd3,
      ACT_EXPR_UPD  = 3'd4,
      ACT_RETIRED   = 3'd5
   } action_type;

   // One voice table entry; expr packs glide[23:16] press[15:8] slide[7:0]
   typedef struct packed {
      logic             active;
      logic             releasing;
      logic [6:0]       note;
      logic [3:0]       source;
      logic [AGEW-1:0]  age;
      logic [EXPRW-1:0] expr;
   } entry_type;

   // One result transaction
   typedef struct packed {
      action_type       action;
      logic [3:0]       voice;
      logic [6:0]       note;
      logic [3:0]       source;
      logic [7:0]       velocity;
      logic [EXPRW-1:0] expr;
      logic             last;
   } res_type;

   // Low four bits of a slot number
   function automatic logic [3:0] slot_voice(logic [IDXW-1:0] idx);
      logic [IDXW+3:0] wide;
      wide = {4'b0000, idx};
      return wide[3:0];
   endfunction

endpackage

/* design/poly_voice_allocator_top.sv */
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  command, note, source, velocity, expression, slot
// rsp_      out        rsp_valid/rsp_ready  action, voice, voice contents, last
//
// Note-on, note-off and expression scan the voice memory one slot per cycle unless a stalled
// rsp_ready holds the scan; the single read port sets this rate. A new request is accepted only in idle.
// Retire reads one slot; a negative note-on or note-off skips the scan.
// Reset clears the slot valid bits and the age counter and loads the default expression.
// A stalled rsp_ready holds the scan whenever a second result would have to be queued.
module poly_voice_allocator_top
   import pva_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic signed [7:0] req_note,
   input  logic [3:0]        req_source,
   input  logic [7:0]        req_velocity,
   input  logic signed [7:0] req_glide_value,
   input  logic [7:0]        req_press_value,
   input  logic [7:0]        req_slide_value,
   input  logic [3:0]        req_retire_voice,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_action,
   output logic [3:0]        rsp_voice,
   output logic [6:0]        rsp_out_note,
   output logic [3:0]        rsp_out_source,
   output logic [7:0]        rsp_out_velocity,
   output logic signed [7:0] rsp_out_glide,
   output logic [7:0]        rsp_out_press,
   output logic [7:0]        rsp_out_slide,
   output logic              rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MODE_ON,
      MODE_OFF,
      MODE_EXPR,
      MODE_RET
   } mode_type;

   state_type        state_ff;
   mode_type         mode_ff;

   // Latched request
   logic [6:0]       note_ff;
   logic             neg_ff;
   logic [3:0]       src_ff;
   logic [7:0]       vel_ff;
   logic [EXPRW-1:0] expr_ff;

   // Block state outside the table
   logic [AGEW-1:0]  age_ctr_ff;
   logic [EXPRW-1:0] default_ff;
   logic [VOICES-1:0] vld_ff;

   // Scan pipeline: issue stage and check stage
   logic             iss_active_ff;
   logic [IDXW-1:0]  iss_idx_ff;
   logic [IDXW-1:0]  iss_last_ff;
   logic             chk_valid_ff;
   logic [IDXW-1:0]  chk_idx_ff;
   entry_type        rd_data_ff;

   // Note-on search results
   logic             held_ff;
   logic             free_found_ff;
   logic [IDXW-1:0]  free_idx_ff;
   logic [IDXW-1:0]  min_idx_ff;
   logic [AGEW-1:0]  min_age_ff;

   // Held-back result (decides last) and output register
   logic             pend_valid_ff;
   res_type          pend_ff;
   logic             rsp_valid_ff;
   res_type          rsp_ff;
   logic [CNTW-1:0]  emit_cnt_ff;

   entry_type        voice_mem [VOICES];

   // Request decode
   logic             req_acc;
   logic             req_neg;
   logic [IDXW+3:0]  ret_wide;
   logic             ret_in_range;
   logic [IDXW-1:0]  ret_idx;
   cmd_type          req_cmd;
   mode_type         req_mode;
   logic             req_skip;

   assign req_acc      = req_valid && req_ready;
   assign req_neg      = req_note[7];
   assign req_cmd      = cmd_type'(req_command);
   assign ret_wide     = {{IDXW{1'b0}}, req_retire_voice};
   assign ret_in_range = ret_wide < (IDXW + 4)'(VOICES);
   assign ret_idx      = ret_wide[IDXW-1:0];

   // Scan mode per command; a negative note-on is handled as a note-off
   always_comb begin
      unique case (req_cmd)
         CMD_NOTE_ON:  req_mode = req_neg ? MODE_OFF : MODE_ON;
         CMD_NOTE_OFF: req_mode = MODE_OFF;
         CMD_EXPR:     req_mode = MODE_EXPR;
         CMD_RETIRE:   req_mode = MODE_RET;
         default:      req_mode = MODE_ON;
      endcase
   end

   // Events that match no voice go straight to the finish step
   assign req_skip = (req_neg && ((req_cmd == CMD_NOTE_ON) || (req_cmd == CMD_NOTE_OFF))) ||
                     ((req_cmd == CMD_RETIRE) && !ret_in_range);

   // Check stage: match, stall and result
   entry_type        e;
   logic             addr_match;
   logic             hit;
   logic             emit_now;
   logic             out_free;
   logic             step_ok;
   logic             adv;
   logic             rd_en;
   logic             scan_done;
   logic             rsp_load;
   res_type          scan_res;
   res_type          alloc_res;
   res_type          final_res;
   logic [IDXW-1:0]  alloc_idx;

   assign e          = rd_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign addr_match = (e.note == note_ff) && ((src_ff == 4'd0) || (e.source == src_ff));

   always_comb begin
      unique case (mode_ff)
         MODE_ON:   hit = 1'b0;
         MODE_OFF:  hit = e.active && addr_match && !e.releasing;
         MODE_EXPR: hit = e.active && (neg_ff || addr_match);
         MODE_RET:  hit = e.active;
         default:   hit = 1'b0;
      endcase
   end

   assign emit_now  = chk_valid_ff && hit && (emit_cnt_ff < CNTW'(MAX_RES));
   assign step_ok   = !emit_now || !pend_valid_ff || out_free;
   assign adv       = (state_ff == ST_SCAN) && (!chk_valid_ff || step_ok);
   assign rd_en     = adv && iss_active_ff;
   assign scan_done = (state_ff == ST_SCAN) && !iss_active_ff && !chk_valid_ff;
   assign alloc_idx = free_found_ff ? free_idx_ff : min_idx_ff;

   // Output register loads from the scan or from the finish step
   assign rsp_load  = ((state_ff == ST_SCAN) && emit_now && pend_valid_ff && step_ok) ||
                      ((state_ff == ST_FINISH) && out_free);

   // Result built from the entry under check
   always_comb begin
      scan_res          = '0;
      scan_res.voice    = slot_voice(chk_idx_ff);
      scan_res.note     = e.note;
      scan_res.source   = e.source;
      scan_res.expr     = (mode_ff == MODE_EXPR) ? expr_ff : e.expr;
      unique case (mode_ff)
         MODE_OFF:  scan_res.action = ACT_RELEASING;
         MODE_EXPR: scan_res.action = ACT_EXPR_UPD;
         MODE_RET:  scan_res.action = ACT_RETIRED;
         default:   scan_res.action = ACT_NONE;
      endcase
   end

   always_comb begin
      alloc_res          = '0;
      alloc_res.action   = free_found_ff ? ACT_STARTED : ACT_STOLEN;
      alloc_res.voice    = slot_voice(alloc_idx);
      alloc_res.note     = note_ff;
      alloc_res.source   = src_ff;
      alloc_res.velocity = vel_ff;
      alloc_res.expr     = default_ff;
   end

   always_comb begin
      final_res      = pend_valid_ff ? pend_ff : '0;
      final_res.last = 1'b1;
   end

   // Memory write: read-modify-write during scan, fresh entry on allocation
   logic             mem_we;
   logic [IDXW-1:0]  mem_waddr;
   entry_type        mem_wdata;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = chk_idx_ff;
      mem_wdata = rd_data_ff;
      if ((state_ff == ST_SCAN) && chk_valid_ff && step_ok && hit) begin
         unique case (mode_ff)
            MODE_OFF: begin
               mem_we              = 1'b1;
               mem_wdata.releasing = 1'b1;
            end
            MODE_EXPR: begin
               mem_we         = 1'b1;
               mem_wdata.expr = expr_ff;
            end
            default: mem_we = 1'b0;
         endcase
      end
      if ((state_ff == ST_ALLOC) && !held_ff) begin
         mem_we              = 1'b1;
         mem_waddr           = alloc_idx;
         mem_wdata.active    = 1'b1;
         mem_wdata.releasing = 1'b0;
         mem_wdata.note      = note_ff;
         mem_wdata.source    = src_ff;
         mem_wdata.age       = age_ctr_ff;
         mem_wdata.expr      = default_ff;
      end
   end

   // Voice memory, one read and one write port; invalid slots read as zero
   always_ff @(posedge clock) begin
      if (mem_we) begin
         voice_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= vld_ff[iss_idx_ff] ? voice_mem[iss_idx_ff] : '0;
      end
   end

   // Control, scan pipeline and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_ON;
         age_ctr_ff    <= '0;
         default_ff    <= DEFAULT_EXPR;
         vld_ff        <= '0;
         iss_active_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         emit_cnt_ff   <= '0;
         held_ff       <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         // Output register: load, else drain on handshake
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  note_ff       <= req_note[6:0];
                  neg_ff        <= req_neg;
                  src_ff        <= req_source;
                  vel_ff        <= req_velocity;
                  expr_ff       <= {req_glide_value, req_press_value, req_slide_value};
                  emit_cnt_ff   <= '0;
                  held_ff       <= 1'b0;
                  free_found_ff <= 1'b0;
                  mode_ff       <= req_mode;
                  iss_idx_ff    <= (req_cmd == CMD_RETIRE) ? ret_idx : '0;
                  iss_last_ff   <= (req_cmd == CMD_RETIRE) ? ret_idx : LAST_IDX;
                  iss_active_ff <= !req_skip;
                  state_ff      <= req_skip ? ST_FINISH : ST_SCAN;
                  // an all-voice expression also sets the defaults
                  if ((req_cmd == CMD_EXPR) && req_neg) begin
                     default_ff <= {req_glide_value, req_press_value, req_slide_value};
                  end
               end
            end

            ST_SCAN: begin
               if (adv) begin
                  // issue the next read, or drain the check stage
                  chk_valid_ff <= iss_active_ff;
                  if (iss_active_ff) begin
                     chk_idx_ff <= iss_idx_ff;
                     if (iss_idx_ff == iss_last_ff) begin
                        iss_active_ff <= 1'b0;
                     end else begin
                        iss_idx_ff <= iss_idx_ff + 1'b1;
                     end
                  end
               end

               if (chk_valid_ff && step_ok) begin
                  // note-on search: held note, first free slot, oldest slot
                  if (mode_ff == MODE_ON) begin
                     if (e.active && (e.note == note_ff) && (e.source == src_ff) &&
                         !e.releasing) begin
                        held_ff <= 1'b1;
                     end
                     if (!e.active && !free_found_ff) begin
                        free_found_ff <= 1'b1;
                        free_idx_ff   <= chk_idx_ff;
                     end
                     if ((chk_idx_ff == '0) || (e.age < min_age_ff)) begin
                        min_age_ff <= e.age;
                        min_idx_ff <= chk_idx_ff;
                     end
                  end
                  if (hit && (mode_ff == MODE_RET)) begin
                     vld_ff[chk_idx_ff] <= 1'b0;
                  end
                  // hold one result back so the final one can carry last
                  if (emit_now) begin
                     emit_cnt_ff   <= emit_cnt_ff + 1'b1;
                     pend_ff       <= scan_res;
                     pend_valid_ff <= 1'b1;
                     if (pend_valid_ff) begin
                        rsp_ff <= pend_ff;
                     end
                  end
               end

               if (scan_done) begin
                  state_ff <= (mode_ff == MODE_ON) ? ST_ALLOC : ST_FINISH;
               end
            end

            ST_ALLOC: begin
               if (!held_ff) begin
                  vld_ff[alloc_idx] <= 1'b1;
                  age_ctr_ff        <= age_ctr_ff + 1'b1;
                  pend_ff           <= alloc_res;
                  pend_valid_ff     <= 1'b1;
               end
               state_ff <= ST_FINISH;
            end

            ST_FINISH: begin
               if (out_free) begin
                  rsp_ff        <= final_res;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_ff.action;
   assign rsp_voice        = rsp_ff.voice;
   assign rsp_out_note     = rsp_ff.note;
   assign rsp_out_source   = rsp_ff.source;
   assign rsp_out_velocity = rsp_ff.velocity;
   assign rsp_out_glide    = rsp_ff.expr[23:16];
   assign rsp_out_press    = rsp_ff.expr[15:8];
   assign rsp_out_slide    = rsp_ff.expr[7:0];
   assign rsp_last         = rsp_ff.last;

   // No result is held back between transactions
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held-back result left over in idle");

   // The check stage only runs during a scan
   assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (state_ff == ST_SCAN))
      else $error("check stage valid outside scan");

   // The result count never passes its cap
   assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff <= CNTW'(MAX_RES))
      else $error("result count overflow");

   // The age counter only moves when a voice is allocated
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ALLOC) |=> $stable(age_ctr_ff))
      else $error("age counter moved outside allocation");

   // A result leaves the output register with last only from the finish step
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last && !$past(rsp_valid_ff && rsp_ff.last))
         |-> ($past(state_ff) == ST_FINISH))
      else $error("last result issued outside finish");

endmodule
